FILE: sv/ics_pkg.sv
`default_nettype none

package ics_pkg;

   localparam int FRAME_BYTES = 1177;
   localparam int FRAME_AW    = $clog2(FRAME_BYTES);
   localparam int FRAME_NW    = $clog2(FRAME_BYTES + 1);
   localparam int PROD_W      = 32 + FRAME_NW;
   localparam int ADDR_W      = 11;
   localparam int KEY_WORDS   = 8;
   localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
   localparam int ROT         = 7;

   localparam logic [63:0] STEP_ADD  = 64'hA0761D6478BD642F;
   localparam logic [63:0] STEP_ADD2 = STEP_ADD + STEP_ADD;
   localparam logic [63:0] STEP_MIX  = 64'hE7037ED1A0B428DB;

   typedef enum logic {
      CMD_FRAME_WRITE = 1'b0,
      CMD_CIPHER      = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] value;
      logic       last;
   } item_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } wy_en_type;

endpackage

`default_nettype wire

FILE: sv/ics_ram.sv
`default_nettype none

module ics_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1177
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/ics_wymul.sv
`default_nettype none

module ics_wymul (
   input  wire logic                  clock,
   input  wire ics_pkg::wy_en_type    en,
   input  wire logic [63:0]           operand,
   output logic      [63:0]           mixed_ff
);

   import ics_pkg::*;

   logic [63:0] a;
   logic [63:0] b;
   logic [63:0] ll_in;
   logic [63:0] lh_full;
   logic [63:0] hl_full;
   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [31:0] cross_sum;
   logic [63:0] m;
   logic [63:0] mixed_in;

   // low 64 bits of a 64x64 product from three 32x32 partials
   always_comb begin
      a       = operand ^ STEP_MIX;
      b       = operand | 64'd1;
      ll_in   = 64'(a[31:0]) * 64'(b[31:0]);
      lh_full = 64'(a[31:0]) * 64'(b[63:32]);
      hl_full = 64'(a[63:32]) * 64'(b[31:0]);
   end

   always_comb begin
      cross_sum = lh_ff + hl_ff;
      m         = ll_ff + {cross_sum, 32'd0};
      mixed_in  = m ^ {32'd0, m[63:32]};
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         ll_ff <= ll_in;
         lh_ff <= lh_full[31:0];
         hl_ff <= hl_full[31:0];
      end
      if (en.load_b) begin
         mixed_ff <= mixed_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/indexed_keystream_xor_cipher.sv
`default_nettype none

// Byte cipher with a seven-stage pipeline that takes one word per clock while
// req_stall is low. Words keep their order; frame writes (command 0) flow
// down the same pipeline and update the frame memory at the stage that
// reads it, so a data byte always sees every frame write taken before it.
// Frame writes give no result. The frame memory holds no defined value after
// reset: every entry a data byte may select must be written first. The user
// must write key words only while the pipeline is empty; the block itself
// does not enforce it. A stalled result backs up one stage at a time, so
// bubbles are squeezed out before the input is stalled.

module indexed_keystream_xor_cipher (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_command,
   input  wire logic [ics_pkg::ADDR_W-1:0]      req_frame_address,
   input  wire logic [7:0]                      req_byte_value,
   input  wire logic [63:0]                     req_byte_position,
   input  wire logic                            req_last_byte,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_data_out,
   output logic                                 rsp_last_out,

   input  wire logic                            csr_write_enable,
   input  wire logic [ics_pkg::KEY_IDX_W-1:0]   csr_index,
   input  wire logic [63:0]                     csr_write_data
);

   import ics_pkg::*;

   logic [63:0] key_ff [KEY_WORDS];

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, v6_in, rsp_valid_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

   item_type item1_ff, item2_ff, item3_ff, item4_ff, item5_ff, item6_ff;
   item_type item_in;
   logic [ADDR_W-1:0] addr1_ff, addr2_ff, addr3_ff, addr4_ff;

   logic [63:0] pos1_ff, pos2_ff;
   logic [63:0] pos1_in, pos2_in;
   logic [5:0]  top2_ff, top3_ff;

   logic [63:0] r1, r2, chaos;
   wy_en_type   en_pos, en_chaos;

   logic [63:0] key_word;
   logic [7:0]  key_byte;
   logic [7:0]  mix;
   logic [63:0] mix2_in, mix2_ff;
   logic [PROD_W-1:0] ph_in, pl_in, ph_ff, pl_ff;
   logic [PROD_W:0]   frame_sum;
   logic [FRAME_AW-1:0] frame_index;
   logic ram_we;
   logic [7:0] ram_rdata;
   logic [7:0] f6_ff;

   logic [31:0] arx_sum, arx_rot, arx;
   logic [7:0]  data_in, rsp_data_ff;
   logic        rsp_last_ff;

   // stage readiness, bubbles collapse
   always_comb begin
      rdy_out = !rsp_valid_ff || !rsp_stall;
      rdy6    = !v6_ff || rdy_out;
      rdy5    = !v5_ff || rdy6;
      rdy4    = !v4_ff || rdy5;
      rdy3    = !v3_ff || rdy4;
      rdy2    = !v2_ff || rdy3;
      rdy1    = !v1_ff || rdy2;
   end

   assign req_stall = !rdy1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last_out = rsp_last_ff;

   always_comb begin
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
      v5_in = rdy5 ? v4_ff : v5_ff;
      v6_in = rdy6 ? v5_ff : v6_ff;
      rsp_valid_in = rdy_out ? (v6_ff && item6_ff.cmd == CMD_CIPHER) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         v5_ff        <= v5_in;
         v6_ff        <= v6_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // key words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= 64'd0;
         end
      end else if (csr_write_enable) begin
         key_ff[csr_index] <= csr_write_data;
      end
   end

   // stage 1: advance position once and twice
   always_comb begin
      item_in.cmd   = cmd_type'(req_command);
      item_in.value = req_byte_value;
      item_in.last  = req_last_byte;
      pos1_in       = req_byte_position + STEP_ADD;
      pos2_in       = req_byte_position + STEP_ADD2;
   end

   assign en_pos.load_a   = rdy2;
   assign en_pos.load_b   = rdy3;
   assign en_chaos.load_a = rdy5;
   assign en_chaos.load_b = rdy6;

   ics_wymul u_wy_first (
      .clock    (clock),
      .en       (en_pos),
      .operand  (pos1_ff),
      .mixed_ff (r1)
   );

   ics_wymul u_wy_second (
      .clock    (clock),
      .en       (en_pos),
      .operand  (pos2_ff),
      .mixed_ff (r2)
   );

   // stage 4: key byte pick and frame index partials
   always_comb begin
      key_word = key_ff[r1[63:64-KEY_IDX_W]];
      key_byte = key_word[{r1[60:58], 3'b000} +: 8];
      mix      = {2'b00, top3_ff} ^ key_byte;
      mix2_in  = {56'd0, mix} + STEP_ADD;
      ph_in    = PROD_W'(r2[63:32]) * PROD_W'(FRAME_BYTES);
      pl_in    = PROD_W'(r2[31:0]) * PROD_W'(FRAME_BYTES);
   end

   ics_wymul u_wy_chaos (
      .clock    (clock),
      .en       (en_chaos),
      .operand  (mix2_ff),
      .mixed_ff (chaos)
   );

   // stage 5: frame memory access
   always_comb begin
      frame_sum   = (PROD_W+1)'(ph_ff) + (PROD_W+1)'(pl_ff[PROD_W-1:32]);
      frame_index = frame_sum[32 +: FRAME_AW];
      ram_we      = v4_ff && rdy5 && item4_ff.cmd == CMD_FRAME_WRITE
                    && 32'(addr4_ff) < 32'(FRAME_BYTES);
   end

   ics_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (FRAME_AW'(addr4_ff)),
      .wr_data (item4_ff.value),
      .rd_en   (rdy5),
      .rd_addr (frame_index),
      .rd_data (ram_rdata)
   );

   // output stage: add-rotate-xor round on the low word of chaos
   always_comb begin
      arx_sum = chaos[31:0] + {24'd0, f6_ff};
      arx_rot = (arx_sum << ROT) | (arx_sum >> (32 - ROT));
      arx     = arx_rot ^ {24'd0, f6_ff};
      data_in = item6_ff.value ^ chaos[7:0] ^ arx[7:0];
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         item1_ff <= item_in;
         addr1_ff <= req_frame_address;
         pos1_ff  <= pos1_in;
         pos2_ff  <= pos2_in;
      end
      if (rdy2) begin
         item2_ff <= item1_ff;
         addr2_ff <= addr1_ff;
         top2_ff  <= pos1_ff[63:58];
      end
      if (rdy3) begin
         item3_ff <= item2_ff;
         addr3_ff <= addr2_ff;
         top3_ff  <= top2_ff;
      end
      if (rdy4) begin
         item4_ff <= item3_ff;
         addr4_ff <= addr3_ff;
         mix2_ff  <= mix2_in;
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
      end
      if (rdy5) begin
         item5_ff <= item4_ff;
      end
      if (rdy6) begin
         item6_ff <= item5_ff;
         f6_ff    <= ram_rdata;
      end
      if (rdy_out && v6_ff) begin
         rsp_data_ff <= data_in;
         rsp_last_ff <= item6_ff.last;
      end
   end

   a_result_from_cipher: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v6_ff && item6_ff.cmd == CMD_CIPHER))
      else $error("result without a cipher word in the last stage");

   a_stage6_holds: assert property (@(posedge clock) disable iff (reset)
      v6_ff && !rdy6 |=> v6_ff && $stable(item6_ff))
      else $error("blocked word lost from last stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted word missing from first stage");

   a_no_write_on_read_stage: assert property (@(posedge clock) disable iff (reset)
      v5_ff && !rdy5 |=> $stable(ram_rdata))
      else $error("frame read data changed while stage held");

endmodule

`default_nettype wire
